// File: src/snpf_pkg.sv
`timescale 1ns / 1ps
package snpf_pkg;

  localparam int COORD_W    = 32;
  localparam int POINT_W    = 3 * COORD_W;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int MIN_NBR_W  = 4;
  localparam int NBR_CNT_W  = 4;
  localparam int NUM_BELOW  = 4;
  localparam int NUM_ABOVE  = 3;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 11'd576;
  localparam logic [MIN_NBR_W-1:0]  MIN_NBR_RST      = 4'd4;

  typedef enum logic {
    OP_POINT = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_MIN_NBR      = 2'd2
  } cfg_idx_e;

  // lookahead neighbors, in order: right, lower left, below, lower right
  typedef struct packed {
    logic                 interior;
    logic                 frame_end;
    logic [NUM_BELOW-1:0] late;
    logic [NUM_BELOW-1:0] fwd_hit;
    logic                 fwd_val;
  } dec_ctrl_t;

  // a point is invalid when every coordinate is +0 or -0
  function automatic logic point_valid(input logic [POINT_W-1:0] p);
    logic v;
    v = (|p[COORD_W-2:0]) | (|p[2*COORD_W-2:COORD_W])
      | (|p[3*COORD_W-2:2*COORD_W]);
    return v;
  endfunction

endpackage

// File: src/snpf_ram.sv
`timescale 1ns / 1ps
module snpf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/snpf_ctrl.sv
`timescale 1ns / 1ps
module snpf_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int PTR_W = $clog2(MAX_WIDTH + 2)
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic [snpf_pkg::CFG_DATA_W-1:0]          frame_width_i,
  input  logic [snpf_pkg::CFG_DATA_W-1:0]          frame_height_i,
  input  logic                                     accept_i,
  input  snpf_pkg::op_e                            op_i,
  input  logic                                     new_valid_i,
  output logic                                     decide_o,
  output snpf_pkg::dec_ctrl_t                      dec_ctrl_o,
  output logic [PTR_W-1:0]                         wr_ptr_o,
  output logic [PTR_W-1:0]                         rd_ptr_o,
  output logic [snpf_pkg::NUM_BELOW-1:0][PTR_W-1:0] below_raddr_o,
  output logic [snpf_pkg::NUM_ABOVE-1:0][PTR_W-1:0] above_raddr_o
);
  import snpf_pkg::*;

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  logic [COL_W-1:0] dec_col_q, dec_col_d;
  logic [ROW_W-1:0] dec_row_q, dec_row_d;
  logic [PTR_W-1:0] pend_q, pend_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;

  logic [WW-1:0]    w;
  logic [HW-1:0]    h;
  logic [PTR_W-1:0] w_p;
  logic             is_point;
  logic             decide;
  logic [PTR_W-1:0] newest;
  logic [NUM_BELOW-1:0][PTR_W-1:0] off;
  logic [NUM_BELOW-1:0] late;
  logic [NUM_BELOW-1:0] fwd_hit;
  logic [WW-1:0]    col_inc;
  logic [HW-1:0]    row_inc;
  logic [HW-1:0]    row_t;
  logic             interior;
  logic             frame_end;

  // geometry is clamped and read live on every beat
  always_comb begin
    if (frame_width_i == '0) begin
      w = WW'(1);
    end else if (32'(frame_width_i) > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(frame_width_i);
    end
    if (frame_height_i == '0) begin
      h = HW'(1);
    end else if (32'(frame_height_i) > 32'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(frame_height_i);
    end
  end

  assign w_p      = PTR_W'(w);
  assign is_point = (op_i == OP_POINT);
  assign decide   = is_point ? (pend_q > w_p) : (pend_q != '0);
  assign newest   = is_point ? pend_q : pend_q - PTR_W'(1);

  // right, lower left, below, lower right
  assign off[0] = PTR_W'(1);
  assign off[1] = w_p - PTR_W'(1);
  assign off[2] = w_p;
  assign off[3] = w_p + PTR_W'(1);

  always_comb begin
    for (int k = 0; k < NUM_BELOW; k++) begin
      late[k]          = off[k] > newest;
      fwd_hit[k]       = is_point && (off[k] == pend_q);
      below_raddr_o[k] = rd_ptr_q + off[k];
    end
  end

  assign above_raddr_o[0] = rd_ptr_q - w_p - PTR_W'(1);
  assign above_raddr_o[1] = rd_ptr_q - w_p;
  assign above_raddr_o[2] = rd_ptr_q - w_p + PTR_W'(1);

  assign col_inc   = WW'(dec_col_q) + WW'(1);
  assign row_inc   = HW'(dec_row_q) + HW'(1);
  assign interior  = (dec_col_q != '0) && (col_inc < w) && (dec_row_q != '0) && (row_inc < h);
  assign frame_end = (col_inc == w) && (row_inc == h);

  always_comb begin
    if (col_inc >= w) begin
      dec_col_d = '0;
      row_t     = row_inc;
    end else begin
      dec_col_d = COL_W'(col_inc);
      row_t     = HW'(dec_row_q);
    end
    dec_row_d = (row_t >= h) ? '0 : ROW_W'(row_t);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    pend_d   = pend_q;
    if (is_point) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
      if (!decide) begin
        pend_d = pend_q + PTR_W'(1);
      end
    end else if (decide) begin
      pend_d = pend_q - PTR_W'(1);
    end
    if (decide) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_col_q <= '0;
      dec_row_q <= '0;
      pend_q    <= '0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
    end else if (accept_i) begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      pend_q   <= pend_d;
      if (decide) begin
        dec_col_q <= dec_col_d;
        dec_row_q <= dec_row_d;
      end
    end
  end

  assign decide_o   = decide;
  assign dec_ctrl_o = '{
    interior:  interior,
    frame_end: frame_end,
    late:      late,
    fwd_hit:   fwd_hit,
    fwd_val:   new_valid_i
  };
  assign wr_ptr_o   = wr_ptr_q;
  assign rd_ptr_o   = rd_ptr_q;

`ifndef SYNTHESIS
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PTR_W'(MAX_WIDTH + 1))
    else $error("pending count beyond one row plus one");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_ptr_q + pend_q == wr_ptr_q)
    else $error("decide pointer lost track of write pointer");

  a_empty_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (op_i == OP_DRAIN) && (pend_q == '0) |-> !decide_o)
    else $error("drain with nothing pending made a decision");
`endif

endmodule

// File: src/snpf_decide.sv
`timescale 1ns / 1ps
module snpf_decide #(
  parameter int MAX_WIDTH = 1024,
  localparam int PTR_W = $clog2(MAX_WIDTH + 2)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  snpf_pkg::dec_ctrl_t               dec_ctrl_i,
  input  logic [PTR_W-1:0]                  pos_i,
  input  logic [snpf_pkg::NUM_BELOW-1:0]    below_rdata_i,
  input  logic [snpf_pkg::NUM_ABOVE-1:0]    above_rdata_i,
  input  logic [snpf_pkg::POINT_W-1:0]      point_rdata_i,
  input  logic [snpf_pkg::MIN_NBR_W-1:0]    min_nbr_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [snpf_pkg::POINT_W-1:0]      out_point_o,
  output logic                              out_last_o,
  output logic                              free_o,
  output logic                              flt_we_o,
  output logic [PTR_W-1:0]                  flt_waddr_o,
  output logic                              flt_wdata_o
);
  import snpf_pkg::*;

  logic                 s1_q;
  dec_ctrl_t            s1_ctrl_q;
  logic [PTR_W-1:0]     s1_pos_q;
  logic                 last_dec_q;
  logic                 out_valid_q;
  logic [POINT_W-1:0]   out_point_q;
  logic                 out_last_q;

  logic [NUM_BELOW-1:0] below_eff;
  logic [7:0]           nbr;
  logic [NBR_CNT_W-1:0] count;
  logic                 center;
  logic                 drop;
  logic                 s1_adv;

  // neighbors below and to the right are raw; not yet arrived counts as invalid
  always_comb begin
    for (int k = 0; k < NUM_BELOW; k++) begin
      if (s1_ctrl_q.late[k]) begin
        below_eff[k] = 1'b0;
      end else if (s1_ctrl_q.fwd_hit[k]) begin
        below_eff[k] = s1_ctrl_q.fwd_val;
      end else begin
        below_eff[k] = below_rdata_i[k];
      end
    end
  end

  // left neighbor is always the previous decision
  assign nbr = {above_rdata_i, last_dec_q, below_eff};

  always_comb begin
    count = '0;
    for (int i = 0; i < 8; i++) begin
      count = count + NBR_CNT_W'(nbr[i]);
    end
  end

  assign center = point_valid(point_rdata_i);
  assign drop   = s1_ctrl_q.interior && center && (count < NBR_CNT_W'(min_nbr_i));
  assign s1_adv = s1_q && (!out_valid_q || out_ready_i);
  assign free_o = !s1_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= 1'b0;
      out_valid_q <= 1'b0;
      last_dec_q  <= 1'b0;
    end else begin
      if (load_i) begin
        s1_q <= 1'b1;
      end else if (s1_adv) begin
        s1_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
        last_dec_q  <= center && !drop;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_ctrl_q <= dec_ctrl_i;
      s1_pos_q  <= pos_i;
    end
    if (s1_adv) begin
      out_point_q <= drop ? '0 : point_rdata_i;
      out_last_q  <= s1_ctrl_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_point_o = out_point_q;
  assign out_last_o  = out_last_q;
  assign flt_we_o    = s1_adv;
  assign flt_waddr_o = s1_pos_q;
  assign flt_wdata_o = center && !drop;

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("decision loaded while the decide stage was stalled");
`endif

endmodule

// File: src/sparse_neighbor_point_filter.sv
`timescale 1ns / 1ps
// 3x3 neighbor-count outlier filter for an organized point stream in raster order. Each beat
// is either a new point (tuser 0) or a drain request (tuser 1); a valid interior point with
// fewer than min_neighbors valid neighbors is sent out as all zeros, border points pass as is.
// Points above and to the left are judged after their own filtering, the rest as received.
// A point comes out once its lower-right neighbor has arrived, so results trail the input by
// frame_width+1 points; drain beats flush the tail, one point each. The block takes one beat
// per clock while the decide stage is free: a decision reads the point store and validity rings
// in the accept cycle and resolves in the decide stage, which holds under output back-pressure;
// the result is then registered. The rate is set only by the output handshake. Validity lives
// in two sets of one-bit rings (raw and filtered), one copy per ring tap, the pending points in
// one 96-bit store; none needs clearing after reset. Geometry may be changed between frames.
module sparse_neighbor_point_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // x_bits, y_bits, z_bits
  input  logic [snpf_pkg::POINT_W-1:0]          s_axis_tdata,
  // operation
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // out_x_bits, out_y_bits, out_z_bits
  output logic [snpf_pkg::POINT_W-1:0]          m_axis_tdata,
  output logic                                  m_axis_tlast,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [snpf_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [snpf_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import snpf_pkg::*;

  localparam int PTR_W = $clog2(MAX_WIDTH + 2);
  localparam int DEPTH = 2 ** PTR_W;

  logic [CFG_DATA_W-1:0] frame_width_q;
  logic [CFG_DATA_W-1:0] frame_height_q;
  logic [MIN_NBR_W-1:0]  min_nbr_q;

  logic                             accept;
  logic                             is_point;
  logic                             new_valid;
  logic                             decide;
  logic                             load;
  dec_ctrl_t                        dec_ctrl;
  logic [PTR_W-1:0]                 wr_ptr;
  logic [PTR_W-1:0]                 rd_ptr;
  logic [NUM_BELOW-1:0][PTR_W-1:0]  below_raddr;
  logic [NUM_ABOVE-1:0][PTR_W-1:0]  above_raddr;
  logic [NUM_BELOW-1:0]             below_rdata;
  logic [NUM_ABOVE-1:0]             above_rdata;
  logic [POINT_W-1:0]               point_rdata;
  logic                             free;
  logic                             flt_we;
  logic [PTR_W-1:0]                 flt_waddr;
  logic                             flt_wdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      min_nbr_q      <= MIN_NBR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        CFG_MIN_NBR:      min_nbr_q      <= cfg_data_i[MIN_NBR_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_point      = (op_e'(s_axis_tuser) == OP_POINT);
  assign new_valid     = point_valid(s_axis_tdata);
  assign load          = accept && decide;

  snpf_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .accept_i       (accept),
    .op_i           (op_e'(s_axis_tuser)),
    .new_valid_i    (new_valid),
    .decide_o       (decide),
    .dec_ctrl_o     (dec_ctrl),
    .wr_ptr_o       (wr_ptr),
    .rd_ptr_o       (rd_ptr),
    .below_raddr_o  (below_raddr),
    .above_raddr_o  (above_raddr)
  );

  // pending points, written on arrival and read when decided
  snpf_ram #(
    .WIDTH (POINT_W),
    .DEPTH (DEPTH)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_point),
    .waddr_i (wr_ptr),
    .wdata_i (s_axis_tdata),
    .re_i    (load),
    .raddr_i (rd_ptr),
    .rdata_o (point_rdata)
  );

  // raw validity, one copy per lookahead tap
  for (genvar k = 0; k < NUM_BELOW; k++) begin : g_below
    snpf_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
    ) u_raw_ram (
      .clk_i   (clk_i),
      .we_i    (accept && is_point),
      .waddr_i (wr_ptr),
      .wdata_i (new_valid),
      .re_i    (load),
      .raddr_i (below_raddr[k]),
      .rdata_o (below_rdata[k])
    );
  end

  // filtered validity, one copy per tap of the row above
  for (genvar j = 0; j < NUM_ABOVE; j++) begin : g_above
    snpf_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
    ) u_flt_ram (
      .clk_i   (clk_i),
      .we_i    (flt_we),
      .waddr_i (flt_waddr),
      .wdata_i (flt_wdata),
      .re_i    (load),
      .raddr_i (above_raddr[j]),
      .rdata_o (above_rdata[j])
    );
  end

  snpf_decide #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_decide (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .dec_ctrl_i    (dec_ctrl),
    .pos_i         (rd_ptr),
    .below_rdata_i (below_rdata),
    .above_rdata_i (above_rdata),
    .point_rdata_i (point_rdata),
    .min_nbr_i     (min_nbr_q),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_point_o   (m_axis_tdata),
    .out_last_o    (m_axis_tlast),
    .free_o        (free),
    .flt_we_o      (flt_we),
    .flt_waddr_o   (flt_waddr),
    .flt_wdata_o   (flt_wdata)
  );

endmodule

// File: tb/sv/snpf_filter_checker.sv
`timescale 1ns / 1ps
module snpf_filter_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  // x_bits, y_bits, z_bits
  input  logic [snpf_pkg::POINT_W-1:0]      s_axis_tdata,
  // operation
  input  logic                              s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_x_bits, out_y_bits, out_z_bits
  input  logic [snpf_pkg::POINT_W-1:0]      m_axis_tdata,
  input  logic                              m_axis_tlast,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_o,
  input  logic [snpf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [snpf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output int                                mismatches_o,
  output int                                awaiting_o
);
  import snpf_pkg::*;

  localparam int STORE_DEPTH = MAX_WIDTH + 1;
  localparam int RING_DEPTH  = 2 * MAX_WIDTH + 3;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               last;
  } filtered_t;

  logic [POINT_W-1:0]    raw_store [STORE_DEPTH];
  bit                    vld_ring  [RING_DEPTH];
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  logic [MIN_NBR_W-1:0]  min_nbr_reg;
  int unsigned           dec_col;
  int unsigned           dec_row;
  int unsigned           held;
  int unsigned           store_wr;
  int unsigned           ring_wr;
  filtered_t             filtered_q [$];
  int                    errors;

  function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned hi);
    if (v == '0) return 1;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  function automatic void check_field(input string name, input logic [COORD_W-1:0] want,
                                      input logic [COORD_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // decide the oldest pending point; newest_off is how far ahead the newest arrival sits
  function automatic void judge_oldest(input int unsigned slot, input int unsigned vpos,
                                       input int unsigned newest_off, input int unsigned w,
                                       input int unsigned h);
    logic [POINT_W-1:0] pt;
    bit                 keep;
    int unsigned        nbrs;
    int                 iw;
    int                 pos;
    int                 taps [8];
    filtered_t          res;
    pt   = raw_store[slot];
    keep = vld_ring[vpos];
    iw   = int'(w);
    taps = '{-iw - 1, -iw, -iw + 1, -1, 1, iw - 1, iw, iw + 1};
    if (keep && dec_col > 0 && dec_col + 1 < w && dec_row > 0 && dec_row + 1 < h) begin
      nbrs = 0;
      foreach (taps[k]) begin
        // neighbors not yet received count as invalid
        if (taps[k] > 0 && taps[k] > int'(newest_off)) continue;
        pos = (int'(vpos) + RING_DEPTH + taps[k]) % RING_DEPTH;
        nbrs += 32'(vld_ring[pos]);
      end
      if (nbrs < 32'(min_nbr_reg)) begin
        pt   = '0;
        keep = 1'b0;
      end
    end
    // in place: later points see this one after filtering
    vld_ring[vpos] = keep;
    res.x    = pt[COORD_W-1:0];
    res.y    = pt[2*COORD_W-1:COORD_W];
    res.z    = pt[3*COORD_W-1:2*COORD_W];
    res.last = (dec_col + 1 == w) && (dec_row + 1 == h);
    filtered_q.push_back(res);
    dec_col++;
    if (dec_col >= w) begin
      dec_col = 0;
      dec_row++;
    end
    if (dec_row >= h) dec_row = 0;
  endfunction

  always @(posedge clk_i) begin
    int unsigned w;
    int unsigned h;
    int unsigned total;
    filtered_t   got;
    filtered_t   want;
    if (!rst_ni) begin
      width_reg   = FRAME_WIDTH_RST;
      height_reg  = FRAME_HEIGHT_RST;
      min_nbr_reg = MIN_NBR_RST;
      dec_col     = 0;
      dec_row     = 0;
      held        = 0;
      store_wr    = 0;
      ring_wr     = 0;
      vld_ring    = '{default: 1'b0};
      filtered_q.delete();
      errors      = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FRAME_WIDTH:  width_reg = cfg_data_i;
          CFG_FRAME_HEIGHT: height_reg = cfg_data_i;
          CFG_MIN_NBR:      min_nbr_reg = cfg_data_i[MIN_NBR_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        if (op_e'(s_axis_tuser) == OP_POINT) begin
          // sign bits alone do not make a point valid
          vld_ring[ring_wr] = ((s_axis_tdata[COORD_W-1:0] | s_axis_tdata[2*COORD_W-1:COORD_W]
                               | s_axis_tdata[3*COORD_W-1:2*COORD_W]) & 32'h7FFF_FFFF) != '0;
          ring_wr = (ring_wr + 1) % RING_DEPTH;
          total   = held + 1;
          if (total > w + 1 || total > STORE_DEPTH) begin
            judge_oldest((store_wr + STORE_DEPTH - held) % STORE_DEPTH,
                         (ring_wr + RING_DEPTH - total) % RING_DEPTH, total - 1, w, h);
            total--;
          end
          raw_store[store_wr] = s_axis_tdata;
          store_wr = (store_wr + 1) % STORE_DEPTH;
          held     = total;
        end else if (held > 0) begin
          judge_oldest((store_wr + STORE_DEPTH - held) % STORE_DEPTH,
                       (ring_wr + RING_DEPTH - held) % RING_DEPTH, held - 1, w, h);
          held--;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.x    = m_axis_tdata[COORD_W-1:0];
        got.y    = m_axis_tdata[2*COORD_W-1:COORD_W];
        got.z    = m_axis_tdata[3*COORD_W-1:2*COORD_W];
        got.last = m_axis_tlast;
        if (filtered_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual x %h y %h z %h last %b",
                   $time, got.x, got.y, got.z, got.last);
        end else begin
          want = filtered_q.pop_front();
          check_field("x", want.x, got.x);
          check_field("y", want.y, got.y);
          check_field("z", want.z, got.z);
          check_field("last", COORD_W'(want.last), COORD_W'(got.last));
        end
      end
    end
    mismatches_o <= errors;
    awaiting_o   <= filtered_q.size();
  end

endmodule

// File: tb/sv/tb_sparse_neighbor_point_filter.sv
`timescale 1ns / 1ps
module tb_sparse_neighbor_point_filter;
  import snpf_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [POINT_W-1:0]    s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [POINT_W-1:0]    m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int          mismatches;
  int          awaiting;
  int          send_idle_pct = 23;
  int          recv_idle_pct = 55;
  int unsigned cur_w = 1;
  int unsigned held = 0;

  sparse_neighbor_point_filter #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .*
  );

  snpf_filter_checker #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_checker (
    .mismatches_o(mismatches),
    .awaiting_o  (awaiting),
    .*
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #5_000_000;
    $display("[sparse_neighbor_point_filter] ERROR");
    $finish;
  end

  function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned hi);
    if (v == '0) return 1;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  // holes are all-zero points with random sign bits
  function automatic logic [POINT_W-1:0] rand_point(input int hole_pct);
    logic [COORD_W-1:0] c [3];
    int                 only;
    if ($urandom_range(99) < hole_pct) begin
      foreach (c[k]) c[k] = $urandom_range(1) ? 32'h8000_0000 : 32'h0;
    end else begin
      foreach (c[k]) c[k] = $urandom;
      if ($urandom_range(3) == 0) begin
        only = $urandom_range(2);
        foreach (c[k]) if (k != only) c[k] = $urandom_range(1) ? 32'h8000_0000 : 32'h0;
      end
    end
    return {c[2], c[1], c[0]};
  endfunction

  task automatic send_beat(input op_e op, input logic [POINT_W-1:0] pt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= pt;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == OP_POINT) begin
      held++;
      if (held > cur_w + 1) held--;
    end else if (held > 0) begin
      held--;
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (awaiting != 0) @(posedge clk_i);
    // drains with nothing pending may still be in flight
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                              input logic [MIN_NBR_W-1:0] mn);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_MIN_NBR, CFG_DATA_W'(mn));
    cfg_valid_i <= 1'b0;
    cur_w = clamp_dim(w, MAX_W);
  endtask

  task automatic flush_pending();
    while (held > 0) send_beat(OP_DRAIN, rand_point(0));
    send_beat(OP_DRAIN, rand_point(0));
    wait_idle();
  endtask

  // callers pass whole frames, but for the final unfinished one, so geometry changes land on a frame boundary
  task automatic run_phase(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input logic [MIN_NBR_W-1:0] mn, input int npoints);
    int hole_pct;
    set_geometry(w, h, mn);
    hole_pct = 20;
    for (int i = 0; i < npoints; i++) begin
      if (i % cur_w == 0) hole_pct = $urandom_range(70);
      if (i == npoints / 2) wait_idle();
      if ($urandom_range(99) < 3) send_beat(OP_DRAIN, rand_point(0));
      send_beat(OP_POINT, rand_point(hole_pct));
    end
    flush_pending();
  endtask

  initial begin
    logic [POINT_W-1:0] corner_pts [16];
    corner_pts = '{
      {32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      {32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
      {32'h8000_0000, 32'h0000_0000, 32'h8000_0001},
      {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      {32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000},
      {32'h0000_0000, 32'h0000_0000, 32'h3F80_0000},
      {32'h8000_0000, 32'h0000_0001, 32'h0000_0000},
      {32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
      {32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF},
      {32'h4120_0000, 32'hC2C8_0000, 32'h0000_0000},
      {32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      {32'h0080_0000, 32'h8000_0000, 32'h0000_0000},
      {32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
      {32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA},
      {32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555},
      {32'h0000_0001, 32'h0000_0000, 32'h0000_0000}
    };
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= OP_POINT;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_FRAME_WIDTH;
    cfg_data_i    <= '0;
    rst_ni        <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 4x4 frame: zero and negative-zero points, a drain on an empty store,
    // and an interior point drained before its lower-right neighbor arrives
    set_geometry(11'd4, 11'd4, 4'd3);
    send_beat(OP_DRAIN, '1);
    for (int i = 0; i < 16; i++) begin
      if (i == 10) send_beat(OP_DRAIN, '0);
      send_beat(OP_POINT, corner_pts[i]);
    end
    flush_pending();

    run_phase(11'd6, 11'd5, 4'd4, 150);
    run_phase(11'd3, 11'd3, 4'd8, 90);
    run_phase(11'd6, 11'd0, 4'd1, 30);

    send_idle_pct = 55;
    recv_idle_pct <= 23;
    run_phase(11'd8, 11'd6, 4'd0, 192);
    run_phase(11'd5, 11'd7, 4'd15, 140);
    run_phase(11'd0, 11'd20, 4'd2, 40);
    run_phase(11'd32, 11'd16, 4'd7, 512);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_phase(11'd9, 11'd9, 4'd6, 162);
    run_phase(11'd4, 11'd3, 4'd2, 120);
    // height clamps to the maximum; the frame is left unfinished
    run_phase(11'd4, 11'd2047, 4'd5, 240);

    if (mismatches == 0) begin
      $display("[sparse_neighbor_point_filter] OK");
    end else begin
      $display("[sparse_neighbor_point_filter] ERROR");
    end
    $finish;
  end

endmodule
